@@ rtl/core/packet_commit_wait_rendezvous_assert.svh @@
// Assertion macros for the packet commit/wait rendezvous block.
// Taken in by the top level with an include; it needs nothing else.
`ifndef PACKET_COMMIT_WAIT_RENDEZVOUS_ASSERT_SVH
`define PACKET_COMMIT_WAIT_RENDEZVOUS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCWR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcwr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PCWR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcwr: next-cycle check failed");

`endif

@@ rtl/core/pcwr_pkg.sv @@
// Shared types, codes and widths of the packet commit/wait rendezvous block.
// Used by the flag store, the decision logic and the top level; no dependencies.
`default_nettype none

package pcwr_pkg;

  localparam int unsigned NumPacketsDefault = 64;
  localparam int unsigned KindW     = 3;
  localparam int unsigned TaskW     = 11;
  localparam int unsigned ThreadW   = 7;
  localparam int unsigned PacketW   = 6;
  localparam int unsigned ActionW   = 3;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned MaxFlags  = 2 ** PacketW;

  typedef enum logic [KindW-1:0] {
    KIND_COMMIT  = 3'd0,
    KIND_WAIT    = 3'd1,
    KIND_RELEASE = 3'd2,
    KIND_MAP     = 3'd3,
    KIND_COPY    = 3'd4
  } kind_t;

  typedef enum logic [ActionW-1:0] {
    ACT_NONE       = 3'd0,
    ACT_WAKE       = 3'd1,
    ACT_WAKE_MAP   = 3'd2,
    ACT_WAKE_COPY  = 3'd3,
    ACT_RELEASE    = 3'd4,
    ACT_BAD_SENDER = 3'd5,
    ACT_BAD_KIND   = 3'd6
  } action_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_ROLE_RECEIVE        = 3'd0,
    CFG_WAKE_MODE           = 3'd1,
    CFG_LOCAL_TASK          = 3'd2,
    CFG_INIT_REMOTE_TASK    = 3'd3,
    CFG_INIT_REMOTE_THREAD  = 3'd4
  } cfg_index_t;

  localparam logic [1:0] WAKE_MAP  = 2'd1;
  localparam logic [1:0] WAKE_COPY = 2'd2;

  typedef struct packed {
    logic             role_receive;
    logic [1:0]       wake_mode;
    logic [TaskW-1:0] local_task;
  } cfg_t;

  typedef struct packed {
    logic set_wait;
    logic clr_wait;
    logic set_pend;
    logic clr_pend;
  } flag_upd_t;

  typedef struct packed {
    logic waiting;
    logic pending;
  } flag_rd_t;

  typedef struct packed {
    action_t            action;
    logic [TaskW-1:0]   target_task;
    logic [ThreadW-1:0] target_thread;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/pcwr_flags.sv @@
// Per-packet waiting and pending flags, held in flip-flops cleared by reset.
// Uses pcwr_pkg for widths and the read and update structs.
`default_nettype none

module pcwr_flags #(
  parameter int unsigned NUM_PACKETS = pcwr_pkg::NumPacketsDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic [pcwr_pkg::PacketW-1:0] index,
  input  wire pcwr_pkg::flag_upd_t         upd,
  output pcwr_pkg::flag_rd_t               rd
);

  // Only indexes the packet field can carry need storage.
  localparam int unsigned FlagDepth =
    (NUM_PACKETS < pcwr_pkg::MaxFlags) ? NUM_PACKETS : pcwr_pkg::MaxFlags;
  localparam int unsigned FIdxW = (FlagDepth > 1) ? $clog2(FlagDepth) : 1;

  logic [FlagDepth-1:0] waiting;
  logic [FlagDepth-1:0] pending;
  logic [FIdxW-1:0]     fidx;
  logic                 hit;

  assign fidx = index[FIdxW-1:0];
  assign hit  = (32'(index) < 32'(FlagDepth));

  always_comb begin
    rd = '0;
    if (hit) begin
      rd.waiting = waiting[fidx];
      rd.pending = pending[fidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting <= '0;
      pending <= '0;
    end else if (en && hit) begin
      if (upd.set_wait) begin
        waiting[fidx] <= 1'b1;
      end else if (upd.clr_wait) begin
        waiting[fidx] <= 1'b0;
      end
      if (upd.set_pend) begin
        pending[fidx] <= 1'b1;
      end else if (upd.clr_pend) begin
        pending[fidx] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pcwr_decide.sv @@
// Decision logic for one message: checks kind and sender, picks the action
// and target, and says how the packet flags and the remote worker change.
// Uses pcwr_pkg for codes, widths and structs.
`default_nettype none

module pcwr_decide (
  input  wire logic [pcwr_pkg::KindW-1:0]   kind,
  input  wire logic [pcwr_pkg::TaskW-1:0]   source_task,
  input  wire logic [pcwr_pkg::ThreadW-1:0] source_thread,
  input  wire logic                         in_range,
  input  wire pcwr_pkg::cfg_t               cfg,
  input  wire logic [pcwr_pkg::TaskW-1:0]   remote_task,
  input  wire logic [pcwr_pkg::ThreadW-1:0] remote_thread,
  input  wire pcwr_pkg::flag_rd_t           rd,
  output pcwr_pkg::result_t                 res,
  output pcwr_pkg::flag_upd_t               upd,
  output logic                              remote_load
);

  pcwr_pkg::kind_t            k;
  pcwr_pkg::action_t          styled;
  logic                       valid_kind;
  logic [pcwr_pkg::TaskW-1:0] expected;

  assign k = pcwr_pkg::kind_t'(kind);

  // Wake style: receive role is always plain; an unused mode code is plain.
  always_comb begin
    styled = pcwr_pkg::ACT_WAKE;
    if (!cfg.role_receive) begin
      if (cfg.wake_mode == pcwr_pkg::WAKE_MAP) begin
        styled = pcwr_pkg::ACT_WAKE_MAP;
      end else if (cfg.wake_mode == pcwr_pkg::WAKE_COPY) begin
        styled = pcwr_pkg::ACT_WAKE_COPY;
      end
    end
  end

  always_comb begin
    case (k)
      pcwr_pkg::KIND_COMMIT,
      pcwr_pkg::KIND_WAIT:    valid_kind = 1'b1;
      pcwr_pkg::KIND_RELEASE,
      pcwr_pkg::KIND_MAP,
      pcwr_pkg::KIND_COPY:    valid_kind = !cfg.role_receive;
      default:                valid_kind = 1'b0;
    endcase
  end

  assign expected = (k == pcwr_pkg::KIND_COMMIT) ? cfg.local_task : remote_task;

  always_comb begin
    res         = '{action: pcwr_pkg::ACT_NONE, target_task: '0, target_thread: '0};
    upd         = '0;
    remote_load = 1'b0;
    if (!valid_kind) begin
      res = '{action: pcwr_pkg::ACT_BAD_KIND, target_task: source_task,
              target_thread: source_thread};
    end else if (source_task != expected) begin
      res = '{action: pcwr_pkg::ACT_BAD_SENDER, target_task: source_task,
              target_thread: source_thread};
    end else if (in_range) begin
      case (k)
        pcwr_pkg::KIND_COMMIT: begin
          if (rd.waiting) begin
            res = '{action: styled, target_task: remote_task,
                    target_thread: remote_thread};
            upd.clr_wait = 1'b1;
          end else begin
            upd.set_pend = 1'b1;
          end
        end
        pcwr_pkg::KIND_WAIT: begin
          if (rd.pending) begin
            if (cfg.role_receive) begin
              res = '{action: styled, target_task: source_task,
                      target_thread: source_thread};
            end else begin
              res = '{action: styled, target_task: remote_task,
                      target_thread: remote_thread};
            end
            upd.clr_pend = 1'b1;
          end else begin
            upd.set_wait = 1'b1;
            remote_load  = 1'b1;
          end
        end
        pcwr_pkg::KIND_RELEASE: begin
          res = '{action: pcwr_pkg::ACT_RELEASE, target_task: source_task,
                  target_thread: source_thread};
        end
        pcwr_pkg::KIND_MAP: begin
          res = '{action: pcwr_pkg::ACT_WAKE_MAP, target_task: remote_task,
                  target_thread: remote_thread};
        end
        pcwr_pkg::KIND_COPY: begin
          res = '{action: pcwr_pkg::ACT_WAKE_COPY, target_task: remote_task,
                  target_thread: remote_thread};
        end
        default: begin
          res = '{action: pcwr_pkg::ACT_NONE, target_task: '0, target_thread: '0};
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/packet_commit_wait_rendezvous.sv @@
// Packet commit/wait rendezvous between a local committer and a remote waiter.
//
// Messages arrive on the s_ stream: s_tuser is the message kind, s_tdata the
// sender task, sender thread and packet index. Every message gives exactly one
// result transfer on the m_ stream: m_tuser is the action, m_tdata the target
// task, target thread and packet index.
// A message is captured in an input register, decided in one pass of short
// logic against the per-packet flags, and stored in the result register that
// drives m_tvalid. While the receiver does not stall, one message is taken
// per cycle; the flag read-modify-write of a message completes in the cycle
// it leaves the input register, so the next message already sees its effect.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready then falls until m_tready returns.
// Configuration writes come on the cfg_ channel (always ready). The user must
// make them while no message is in flight; the block does not enforce this.
// Writing the initial remote task or thread also loads the recorded remote worker.
// Synchronous reset clears all packet flags, the configuration and the
// recorded remote worker, and empties both registers.
`default_nettype none

`include "packet_commit_wait_rendezvous_assert.svh"

module packet_commit_wait_rendezvous #(
  parameter int unsigned NUM_PACKETS = pcwr_pkg::NumPacketsDefault
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // s_tdata: source_task [10:0], source_thread [17:11], packet_index [23:18]
  input  wire logic [23:0]                     s_tdata,
  // s_tuser: kind [2:0]
  input  wire logic [pcwr_pkg::KindW-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // m_tdata: target_task [10:0], target_thread [17:11], packet_out [23:18]
  output logic [23:0]                          m_tdata,
  // m_tuser: action [2:0]
  output logic [pcwr_pkg::ActionW-1:0]         m_tuser,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pcwr_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [pcwr_pkg::CfgDataW-1:0]   cfg_data
);

  logic                             s1_valid;
  logic [pcwr_pkg::KindW-1:0]       s1_kind;
  logic [pcwr_pkg::TaskW-1:0]       s1_task;
  logic [pcwr_pkg::ThreadW-1:0]     s1_thread;
  logic [pcwr_pkg::PacketW-1:0]     s1_packet;
  logic                             s1_adv;
  logic                             in_range;

  pcwr_pkg::cfg_t                   cfg;
  logic [pcwr_pkg::TaskW-1:0]       remote_task;
  logic [pcwr_pkg::ThreadW-1:0]     remote_thread;

  pcwr_pkg::flag_rd_t               flag_rd;
  pcwr_pkg::flag_upd_t              flag_upd;
  pcwr_pkg::result_t                res;
  logic                             remote_load;

  pcwr_pkg::result_t                out_res;
  logic [pcwr_pkg::PacketW-1:0]     out_packet;

  assign s1_adv    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || s1_adv;
  assign cfg_ready = 1'b1;
  assign in_range  = (32'(s1_packet) < 32'(NUM_PACKETS));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_kind   <= s_tuser;
      s1_task   <= s_tdata[10:0];
      s1_thread <= s_tdata[17:11];
      s1_packet <= s_tdata[23:18];
    end
  end

  // Configuration registers and the recorded remote worker.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg           <= '0;
      remote_task   <= '0;
      remote_thread <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (pcwr_pkg::cfg_index_t'(cfg_index))
        pcwr_pkg::CFG_ROLE_RECEIVE:       cfg.role_receive <= cfg_data[0];
        pcwr_pkg::CFG_WAKE_MODE:          cfg.wake_mode    <= cfg_data[1:0];
        pcwr_pkg::CFG_LOCAL_TASK:         cfg.local_task   <= cfg_data[10:0];
        pcwr_pkg::CFG_INIT_REMOTE_TASK:   remote_task      <= cfg_data[10:0];
        pcwr_pkg::CFG_INIT_REMOTE_THREAD: remote_thread    <= cfg_data[6:0];
        default: begin
        end
      endcase
    end else if (s1_adv && remote_load) begin
      remote_task   <= s1_task;
      remote_thread <= s1_thread;
    end
  end

  pcwr_flags #(
    .NUM_PACKETS (NUM_PACKETS)
  ) u_flags (
    .clk   (clk),
    .rst   (rst),
    .en    (s1_adv),
    .index (s1_packet),
    .upd   (flag_upd),
    .rd    (flag_rd)
  );

  pcwr_decide u_decide (
    .kind          (s1_kind),
    .source_task   (s1_task),
    .source_thread (s1_thread),
    .in_range      (in_range),
    .cfg           (cfg),
    .remote_task   (remote_task),
    .remote_thread (remote_thread),
    .rd            (flag_rd),
    .res           (res),
    .upd           (flag_upd),
    .remote_load   (remote_load)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res    <= res;
      out_packet <= s1_packet;
    end
  end

  assign m_tuser = out_res.action;
  assign m_tdata = {out_packet, out_res.target_thread, out_res.target_task};

  // A packet is never both waited on and pending.
  `PCWR_ASSERT_IMPLY(a_flags_exclusive, clk, rst, s1_valid,
                     !(flag_rd.waiting && flag_rd.pending))
  // A held result blocks the decision stage.
  `PCWR_ASSERT_IMPLY(a_stall_blocks, clk, rst, m_tvalid && !m_tready, !s1_adv)
  // A message for a packet beyond the store that passes the kind and sender checks gives no action.
  `PCWR_ASSERT_NEXT(a_out_of_range_none, clk, rst,
                    s1_adv && !in_range && (res.action != pcwr_pkg::ACT_BAD_KIND) &&
                    (res.action != pcwr_pkg::ACT_BAD_SENDER),
                    m_tuser == pcwr_pkg::ACT_NONE)

endmodule

`default_nettype wire

@@ tb/sv/packet_commit_wait_rendezvous_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for packet_commit_wait_rendezvous: directed and random messages
// in several configurations, with results compared against a behavioral predictor.
// Depends on pcwr_pkg and the RTL of the block; nothing else.

module packet_commit_wait_rendezvous_tb;

  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_MESSAGES = 190;
  localparam logic [pcwr_pkg::KindW-1:0] KIND_FIRST_UNUSED = 3'd5;
  localparam logic [pcwr_pkg::KindW-1:0] KIND_TOP          = 3'd7;

  typedef struct packed {
    logic [pcwr_pkg::KindW-1:0]   kind;
    logic [pcwr_pkg::TaskW-1:0]   src_task;
    logic [pcwr_pkg::ThreadW-1:0] src_thread;
    logic [pcwr_pkg::PacketW-1:0] pkt;
  } rdv_msg_t;

  typedef struct packed {
    pcwr_pkg::action_t            action;
    logic [pcwr_pkg::TaskW-1:0]   tgt_task;
    logic [pcwr_pkg::ThreadW-1:0] tgt_thread;
    logic [pcwr_pkg::PacketW-1:0] pkt;
  } rdv_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [23:0]                    s_tdata = '0;
  logic [pcwr_pkg::KindW-1:0]     s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [23:0]                    m_tdata;
  logic [pcwr_pkg::ActionW-1:0]   m_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pcwr_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [pcwr_pkg::CfgDataW-1:0]  cfg_data = '0;

  packet_commit_wait_rendezvous dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor copy of the configuration and the rendezvous state.
  logic                         role_model = 1'b0;
  logic [1:0]                   wake_model = '0;
  logic [pcwr_pkg::TaskW-1:0]   local_model = '0;
  logic [pcwr_pkg::TaskW-1:0]   worker_task = '0;
  logic [pcwr_pkg::ThreadW-1:0] worker_thread = '0;
  logic                         waiting_flag [pcwr_pkg::MaxFlags];
  logic                         pending_flag [pcwr_pkg::MaxFlags];

  // Values the message generator uses to build well-formed senders.
  logic [pcwr_pkg::TaskW-1:0]   gen_local_task = '0;
  logic [pcwr_pkg::TaskW-1:0]   gen_remote_task = '0;

  rdv_msg_t    pending_msgs[$];
  rdv_result_t expected_results[$];
  rdv_msg_t    msg_on_bus;
  rdv_result_t exp_res, got_res;

  int unsigned burst_left = 0, gap_left = 0;
  int unsigned stall_mode = 0, stall_timer = 0, stall_phase = 0;
  int unsigned messages_sent = 0, results_checked = 0, settings_applied = 0;
  int unsigned error_count = 0;
  int unsigned action_count [8];

  initial begin
    for (int i = 0; i < pcwr_pkg::MaxFlags; i++) begin
      waiting_flag[i] = 1'b0;
      pending_flag[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) action_count[i] = 0;
  end

  function automatic pcwr_pkg::action_t styled_wake();
    if (role_model) return pcwr_pkg::ACT_WAKE;
    if (wake_model == pcwr_pkg::WAKE_MAP) return pcwr_pkg::ACT_WAKE_MAP;
    if (wake_model == pcwr_pkg::WAKE_COPY) return pcwr_pkg::ACT_WAKE_COPY;
    return pcwr_pkg::ACT_WAKE;
  endfunction

  // Works out the result of one message and advances the predictor state.
  function automatic rdv_result_t decide_message(rdv_msg_t m);
    rdv_result_t                r;
    logic                       kind_ok;
    logic [pcwr_pkg::TaskW-1:0] allowed;
    r.action     = pcwr_pkg::ACT_NONE;
    r.tgt_task   = '0;
    r.tgt_thread = '0;
    r.pkt        = m.pkt;
    kind_ok = (m.kind == pcwr_pkg::KIND_COMMIT) || (m.kind == pcwr_pkg::KIND_WAIT) ||
              (!role_model && m.kind <= pcwr_pkg::KIND_COPY);
    allowed = (m.kind == pcwr_pkg::KIND_COMMIT) ? local_model : worker_task;
    if (!kind_ok) begin
      r.action     = pcwr_pkg::ACT_BAD_KIND;
      r.tgt_task   = m.src_task;
      r.tgt_thread = m.src_thread;
    end else if (m.src_task != allowed) begin
      r.action     = pcwr_pkg::ACT_BAD_SENDER;
      r.tgt_task   = m.src_task;
      r.tgt_thread = m.src_thread;
    end else begin
      case (m.kind)
        pcwr_pkg::KIND_COMMIT: begin
          if (waiting_flag[m.pkt]) begin
            r.action     = styled_wake();
            r.tgt_task   = worker_task;
            r.tgt_thread = worker_thread;
            waiting_flag[m.pkt] = 1'b0;
          end else begin
            pending_flag[m.pkt] = 1'b1;
          end
        end
        pcwr_pkg::KIND_WAIT: begin
          if (pending_flag[m.pkt]) begin
            r.action = styled_wake();
            // The receive role answers the waiter itself.
            if (role_model) begin
              r.tgt_task   = m.src_task;
              r.tgt_thread = m.src_thread;
            end else begin
              r.tgt_task   = worker_task;
              r.tgt_thread = worker_thread;
            end
            pending_flag[m.pkt] = 1'b0;
          end else begin
            waiting_flag[m.pkt] = 1'b1;
            worker_task   = m.src_task;
            worker_thread = m.src_thread;
          end
        end
        pcwr_pkg::KIND_RELEASE: begin
          r.action     = pcwr_pkg::ACT_RELEASE;
          r.tgt_task   = m.src_task;
          r.tgt_thread = m.src_thread;
        end
        pcwr_pkg::KIND_MAP: begin
          r.action     = pcwr_pkg::ACT_WAKE_MAP;
          r.tgt_task   = worker_task;
          r.tgt_thread = worker_thread;
        end
        default: begin
          r.action     = pcwr_pkg::ACT_WAKE_COPY;
          r.tgt_task   = worker_task;
          r.tgt_thread = worker_thread;
        end
      endcase
    end
    return r;
  endfunction

  function automatic void push_msg(logic [pcwr_pkg::KindW-1:0] kind,
                                   logic [pcwr_pkg::TaskW-1:0] src_task,
                                   logic [pcwr_pkg::ThreadW-1:0] src_thread,
                                   logic [pcwr_pkg::PacketW-1:0] pkt);
    rdv_msg_t m;
    m.kind       = kind;
    m.src_task   = src_task;
    m.src_thread = src_thread;
    m.pkt        = pkt;
    pending_msgs.push_back(m);
  endfunction

  // Mostly well-formed commits and waits on a few packets so that they meet,
  // with some send-role requests, wrong senders and unknown kinds mixed in.
  function automatic rdv_msg_t random_message();
    rdv_msg_t    m;
    int unsigned pick;
    pick = $urandom_range(99);
    m.src_thread = pcwr_pkg::ThreadW'($urandom_range(127));
    m.pkt = ($urandom_range(3) == 0) ?
            pcwr_pkg::PacketW'($urandom_range(pcwr_pkg::MaxFlags - 1)) :
            pcwr_pkg::PacketW'($urandom_range(7));
    if (pick < 40) begin
      m.kind     = pcwr_pkg::KIND_COMMIT;
      m.src_task = gen_local_task;
    end else if (pick < 76) begin
      m.kind     = pcwr_pkg::KIND_WAIT;
      m.src_task = gen_remote_task;
    end else if (pick < 86) begin
      m.kind     = pcwr_pkg::KindW'($urandom_range(pcwr_pkg::KIND_RELEASE,
                                                   pcwr_pkg::KIND_COPY));
      m.src_task = gen_remote_task;
    end else if (pick < 93) begin
      m.kind     = pcwr_pkg::KindW'($urandom_range(pcwr_pkg::KIND_COMMIT,
                                                   pcwr_pkg::KIND_COPY));
      m.src_task = pcwr_pkg::TaskW'($urandom_range(2047));
    end else begin
      m.kind     = pcwr_pkg::KindW'($urandom_range(KIND_FIRST_UNUSED, KIND_TOP));
      m.src_task = pcwr_pkg::TaskW'($urandom_range(2047));
    end
    return m;
  endfunction

  task automatic write_register(pcwr_pkg::cfg_index_t idx,
                                logic [pcwr_pkg::CfgDataW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pcwr_pkg::CFG_ROLE_RECEIVE:       role_model = value[0];
      pcwr_pkg::CFG_WAKE_MODE:          wake_model = value[1:0];
      pcwr_pkg::CFG_LOCAL_TASK:         local_model = value[pcwr_pkg::TaskW-1:0];
      pcwr_pkg::CFG_INIT_REMOTE_TASK:   worker_task = value[pcwr_pkg::TaskW-1:0];
      pcwr_pkg::CFG_INIT_REMOTE_THREAD: worker_thread = value[pcwr_pkg::ThreadW-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_setting(logic role, logic [1:0] wake,
                               logic [pcwr_pkg::TaskW-1:0] loc,
                               logic [pcwr_pkg::TaskW-1:0] rtask,
                               logic [pcwr_pkg::ThreadW-1:0] rthread);
    write_register(pcwr_pkg::CFG_ROLE_RECEIVE, pcwr_pkg::CfgDataW'(role));
    write_register(pcwr_pkg::CFG_WAKE_MODE, pcwr_pkg::CfgDataW'(wake));
    write_register(pcwr_pkg::CFG_LOCAL_TASK, pcwr_pkg::CfgDataW'(loc));
    write_register(pcwr_pkg::CFG_INIT_REMOTE_TASK, pcwr_pkg::CfgDataW'(rtask));
    write_register(pcwr_pkg::CFG_INIT_REMOTE_THREAD, pcwr_pkg::CfgDataW'(rthread));
    gen_local_task  = loc;
    gen_remote_task = rtask;
    settings_applied++;
  endtask

  // Every message yields one result, so an empty expectation queue means idle.
  // The check is repeated after the drain so that a message the driver picked
  // up in the same step is not missed.
  task automatic wait_idle();
    do begin
      while (pending_msgs.size() != 0 || s_tvalid || expected_results.size() != 0)
        @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end while (pending_msgs.size() != 0 || s_tvalid || expected_results.size() != 0);
  endtask

  function automatic void report_error(string text);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: mismatch: %s", $realtime, text);
  endfunction

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        exp_res = decide_message(msg_on_bus);
        expected_results.push_back(exp_res);
        action_count[exp_res.action]++;
        messages_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
        end
        if (gap_left != 0 || pending_msgs.size() == 0) begin
          if (gap_left != 0) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          msg_on_bus = pending_msgs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= msg_on_bus.kind;
          s_tdata  <= {msg_on_bus.pkt, msg_on_bus.src_thread, msg_on_bus.src_task};
          burst_left--;
        end
      end
    end
  end

  // Monitor: checks each result transfer; the receiver switches between
  // always ready, random, periodic and mostly stalled stretches.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_timer = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_res.action     = pcwr_pkg::action_t'(m_tuser);
        got_res.tgt_task   = m_tdata[10:0];
        got_res.tgt_thread = m_tdata[17:11];
        got_res.pkt        = m_tdata[23:18];
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result action %0d task %0d thread %0d pkt %0d",
                                 got_res.action, got_res.tgt_task, got_res.tgt_thread,
                                 got_res.pkt));
        end else begin
          exp_res = expected_results.pop_front();
          results_checked++;
          if (got_res.action !== exp_res.action || got_res.tgt_task !== exp_res.tgt_task ||
              got_res.tgt_thread !== exp_res.tgt_thread || got_res.pkt !== exp_res.pkt)
            report_error($sformatf(
              "expected action %0d task %0d thread %0d pkt %0d, got %0d %0d %0d %0d",
              exp_res.action, exp_res.tgt_task, exp_res.tgt_thread, exp_res.pkt,
              got_res.action, got_res.tgt_task, got_res.tgt_thread, got_res.pkt));
        end
      end
      if (stall_timer == 0) begin
        stall_mode  = $urandom_range(3);
        stall_timer = $urandom_range(40, 200);
      end else begin
        stall_timer--;
      end
      stall_phase++;
      case (stall_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(1));
        2:       m_tready <= (stall_phase % 5) < 3;
        default: m_tready <= ($urandom_range(7) == 0);
      endcase
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Send role, copy-style wakeups, extreme task and thread numbers.
    apply_setting(1'b0, pcwr_pkg::WAKE_COPY, 11'd2047, 11'd0, 7'd127);
    push_msg(pcwr_pkg::KIND_COMMIT, 11'd2047, 7'd5, 6'd0);   // no waiter: becomes pending
    push_msg(pcwr_pkg::KIND_WAIT, 11'd0, 7'd127, 6'd0);      // pending: answered at once
    push_msg(pcwr_pkg::KIND_WAIT, 11'd0, 7'd3, 6'd63);       // no pending: records the worker
    push_msg(pcwr_pkg::KIND_COMMIT, 11'd2047, 7'd0, 6'd63);  // wakes the recorded worker
    push_msg(pcwr_pkg::KIND_RELEASE, 11'd0, 7'd64, 6'd21);
    push_msg(pcwr_pkg::KIND_MAP, 11'd0, 7'd1, 6'd42);
    push_msg(pcwr_pkg::KIND_COPY, 11'd0, 7'd0, 6'd1);
    push_msg(pcwr_pkg::KIND_COMMIT, 11'd0, 7'd0, 6'd0);      // commit from the wrong task
    push_msg(pcwr_pkg::KIND_WAIT, 11'd2047, 7'd127, 6'd63);  // wait from the wrong task
    push_msg(KIND_FIRST_UNUSED, 11'd0, 7'd9, 6'd2);
    push_msg(KIND_TOP, 11'd1234, 7'd77, 6'd63);              // kind is checked before sender
    push_msg(pcwr_pkg::KIND_COMMIT, 11'd2047, 7'd1, 6'd10);
    push_msg(pcwr_pkg::KIND_COMMIT, 11'd2047, 7'd2, 6'd10);  // pending stays set
    push_msg(pcwr_pkg::KIND_WAIT, 11'd0, 7'd50, 6'd10);
    push_msg(pcwr_pkg::KIND_WAIT, 11'd0, 7'd51, 6'd10);      // left waiting into next setting
    wait_idle();

    // Receive role: plain wakeups, waiter answered directly, requests refused.
    apply_setting(1'b1, pcwr_pkg::WAKE_COPY, 11'd0, 11'd2047, 7'd0);
    push_msg(pcwr_pkg::KIND_COMMIT, 11'd0, 7'd4, 6'd10);
    push_msg(pcwr_pkg::KIND_COMMIT, 11'd0, 7'd4, 6'd33);
    push_msg(pcwr_pkg::KIND_WAIT, 11'd2047, 7'd99, 6'd33);
    push_msg(pcwr_pkg::KIND_RELEASE, 11'd2047, 7'd0, 6'd5);
    push_msg(pcwr_pkg::KIND_MAP, 11'd2047, 7'd0, 6'd5);
    push_msg(pcwr_pkg::KIND_COPY, 11'd2047, 7'd0, 6'd5);
    push_msg(pcwr_pkg::KIND_WAIT, 11'd2047, 7'd127, 6'd62);
    push_msg(pcwr_pkg::KIND_COMMIT, 11'd0, 7'd8, 6'd62);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)
        apply_setting(1'b0, 2'd0, 11'd2047, 11'd2047, 7'd127);
      else if (p == 1)
        apply_setting(1'b1, 2'd1, 11'd0, 11'd0, 7'd0);
      else
        apply_setting(1'(p % 2), 2'(p % 3),
                      pcwr_pkg::TaskW'($urandom_range(2047)),
                      pcwr_pkg::TaskW'($urandom_range(2047)),
                      pcwr_pkg::ThreadW'($urandom_range(127)));
      repeat (PHASE_MESSAGES) pending_msgs.push_back(random_message());
      wait_idle();
    end

    $display("Run covered %0d messages and %0d checked results over %0d settings.",
             messages_sent, results_checked, settings_applied);
    $display("Wakeups %0d/%0d/%0d, releases %0d, bad senders %0d, bad kinds %0d, quiet %0d.",
             action_count[pcwr_pkg::ACT_WAKE], action_count[pcwr_pkg::ACT_WAKE_MAP],
             action_count[pcwr_pkg::ACT_WAKE_COPY], action_count[pcwr_pkg::ACT_RELEASE],
             action_count[pcwr_pkg::ACT_BAD_SENDER], action_count[pcwr_pkg::ACT_BAD_KIND],
             action_count[pcwr_pkg::ACT_NONE]);
    if (error_count == 0) begin
      $display("[packet_commit_wait_rendezvous] OK");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("[packet_commit_wait_rendezvous] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding", expected_results.size());
    $display("[packet_commit_wait_rendezvous] ERROR");
    $finish;
  end

endmodule
